// ===== design/lpso_pkg.sv =====
// Shared types and constants for the largest plus sign order block.
`default_nettype none

package lpso_pkg;

    // Operation codes carried by an input transaction.
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_BLOCK   = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Result field width and its saturation point.
    localparam int ORDER_W   = 6;
    localparam int ORDER_MAX = 63;

    // Control that travels with one cell from the issue stage to the scan stage.
    typedef struct packed {
        logic valid;
        logic bwd;        // backward pass (right and down runs)
        logic first_row;  // first row of the pass: column runs start from zero
        logic row_start;  // first cell of the row: row run starts from zero
        logic blocked;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/largest_plus_sign_order.sv =====
// Top level of the largest plus sign order block: control and memories.
//
// Usage. A transaction is taken at a rising edge with start high and busy low;
// i_op selects clear grid (0), block cell i_row/i_col (1) or compute (2); code 3
// does nothing. The grid size register (0..64 in use, reset 64) is written over
// i_cfg_valid/o_cfg_ready/i_cfg_data. The user must write it only while the
// block is idle; the block does not enforce this. o_cfg_ready is always high.
// Sequencing, with n the grid size in use (capped at MAX_SIDE):
//   block: busy through a row read, then a row write-back; out-of-range
//          cells are dropped without raising busy.
//   clear: busy while the MAX_SIDE blocked-map rows are written, one per cycle.
//   compute: o_order_valid pulses for one cycle after the backward pass ends,
//          or in the cycle after the accepting edge when n is zero. Each pass
//          fetches each blocked-map row in a row state, then visits each cell
//          of it in a cell state for the column-run and forward-min memory
//          accesses; busy stays high until the result cycle ends.
// Reset runs the clearing sweep with busy high, grid size goes to 64 and the
// held order to zero. The receiver cannot stall: o_order is valid only in the
// strobe cycle.
`default_nettype none

module largest_plus_sign_order #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_op,
    input  wire logic [5:0]                   i_row,
    input  wire logic [5:0]                   i_col,
    output logic                              o_order_valid,
    output logic      [lpso_pkg::ORDER_W-1:0] o_order,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [6:0]                   i_cfg_data
);

    localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int FW = 2 * IW;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLEAR  = 7'b0000010,
        ST_BLK_RD = 7'b0000100,
        ST_BLK_WR = 7'b0001000,
        ST_ROW    = 7'b0010000,
        ST_CELL   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } t_state;

    // The result cycle reuses idle-side logic through its own flag below.
    t_state r_state;
    t_state n_state;
    logic   r_emit;
    logic   n_emit;

    logic [6:0]    r_grid_size;
    logic [SW-1:0] n_eff;
    logic [IW-1:0] last_ix;

    logic [IW-1:0] r_i;
    logic [IW-1:0] n_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] n_j;
    logic          r_bwd;
    logic          n_bwd;
    logic [IW-1:0] r_blk_row;
    logic [IW-1:0] r_blk_col;

    lpso_pkg::t_cell_ctl r_s_ctl;
    lpso_pkg::t_cell_ctl n_s_ctl;
    logic [IW-1:0]       r_s_i;
    logic [IW-1:0]       r_s_j;

    logic                accept;
    logic                clear_best;
    logic                last_col;
    logic                last_row;

    // Blocked-map row memory.
    logic                row_we;
    logic [IW-1:0]       row_waddr;
    logic [MAX_SIDE-1:0] row_wdata;
    logic                row_re;
    logic [IW-1:0]       row_raddr;
    logic [MAX_SIDE-1:0] row_rdata;

    // Column run memory.
    logic          col_we;
    logic          col_re;
    logic [SW-1:0] col_rdata;
    logic [SW-1:0] col_run;

    // Forward minimum memory.
    logic          fmin_we;
    logic          fmin_re;
    logic [FW-1:0] fmin_waddr;
    logic [FW-1:0] fmin_raddr;
    logic [SW-1:0] fmin_rdata;
    logic [SW-1:0] fmin_wdata;

    logic [SW-1:0] best;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= 7'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_size <= i_cfg_data;
        end
    end

    // Cap the grid size at the storage side.
    always_comb begin
        if (int'(r_grid_size) > MAX_SIDE) begin
            n_eff = SW'(MAX_SIDE);
        end else begin
            n_eff = SW'(r_grid_size);
        end
        last_ix = IW'(n_eff - SW'(1));
    end

    assign busy   = (r_state != ST_IDLE) || r_emit;
    assign accept = start && !busy;

    assign last_col = r_bwd ? (r_j == '0) : (r_j == last_ix);
    assign last_row = r_bwd ? (r_i == '0) : (r_i == last_ix);

    // Sequence the sweeps, the block read-modify-write and the two scan passes.
    always_comb begin
        n_state    = r_state;
        n_emit     = 1'b0;
        n_i        = r_i;
        n_j        = r_j;
        n_bwd      = r_bwd;
        clear_best = 1'b0;
        n_s_ctl    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (lpso_pkg::t_op'(i_op))
                        lpso_pkg::OP_CLEAR: begin
                            n_i     = '0;
                            n_state = ST_CLEAR;
                        end
                        lpso_pkg::OP_BLOCK: begin
                            if ((i_row < n_eff) && (i_col < n_eff)) begin
                                n_state = ST_BLK_RD;
                            end
                        end
                        lpso_pkg::OP_COMPUTE: begin
                            clear_best = 1'b1;
                            if (n_eff == '0) begin
                                n_emit = 1'b1;
                            end else begin
                                n_i     = '0;
                                n_bwd   = 1'b0;
                                n_state = ST_ROW;
                            end
                        end
                        lpso_pkg::OP_NONE: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                if (int'(r_i) == MAX_SIDE - 1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            ST_BLK_RD: begin
                n_state = ST_BLK_WR;
            end
            ST_BLK_WR: begin
                n_state = ST_IDLE;
            end
            ST_ROW: begin
                n_j     = r_bwd ? last_ix : '0;
                n_state = ST_CELL;
            end
            ST_CELL: begin
                n_s_ctl.valid     = 1'b1;
                n_s_ctl.bwd       = r_bwd;
                n_s_ctl.first_row = r_bwd ? (r_i == last_ix) : (r_i == '0);
                n_s_ctl.row_start = r_bwd ? (r_j == last_ix) : (r_j == '0);
                n_s_ctl.blocked   = row_rdata[r_j];
                if (!last_col) begin
                    n_j = r_bwd ? (r_j - IW'(1)) : (r_j + IW'(1));
                end else if (!last_row) begin
                    n_i     = r_bwd ? (r_i - IW'(1)) : (r_i + IW'(1));
                    n_state = ST_ROW;
                end else if (!r_bwd) begin
                    n_bwd   = 1'b1;
                    n_i     = last_ix;
                    n_state = ST_ROW;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Last cell settles into the best order this cycle.
                n_emit  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_emit  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_bwd   <= 1'b0;
            r_s_ctl <= '0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
            r_i     <= n_i;
            r_j     <= n_j;
            r_bwd   <= n_bwd;
            r_s_ctl <= n_s_ctl;
        end
    end

    // Hold the cell coordinates for the block request and the scan stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_blk_row <= IW'(i_row);
            r_blk_col <= IW'(i_col);
        end
        r_s_i <= r_i;
        r_s_j <= r_j;
    end

    // Blocked-map row access: sweep, read-modify-write, scan fetch.
    always_comb begin
        row_we    = (r_state == ST_CLEAR) || (r_state == ST_BLK_WR);
        row_waddr = (r_state == ST_CLEAR) ? r_i : r_blk_row;
        row_wdata = '0;
        if (r_state == ST_BLK_WR) begin
            row_wdata            = row_rdata;
            row_wdata[r_blk_col] = 1'b1;
        end
        row_re    = (r_state == ST_BLK_RD) || (r_state == ST_ROW);
        row_raddr = (r_state == ST_BLK_RD) ? r_blk_row : r_i;
    end

    lpso_ram #(
        .WIDTH  (MAX_SIDE),
        .ADDR_W (IW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Column runs: the row fetch cycle keeps a column's write ahead of its next read.
    assign col_re = (r_state == ST_CELL);
    assign col_we = r_s_ctl.valid;

    lpso_ram #(
        .WIDTH  (SW),
        .ADDR_W (IW)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_s_j),
        .i_wdata (col_run),
        .i_re    (col_re),
        .i_raddr (r_j),
        .o_rdata (col_rdata)
    );

    // Forward minimum: written in the forward pass, read back in the backward pass.
    assign fmin_re    = (r_state == ST_CELL) && r_bwd;
    assign fmin_raddr = {r_i, r_j};
    assign fmin_we    = r_s_ctl.valid && !r_s_ctl.bwd;
    assign fmin_waddr = {r_s_i, r_s_j};

    lpso_ram #(
        .WIDTH  (SW),
        .ADDR_W (FW)
    ) u_fmin_ram (
        .i_clk   (i_clk),
        .i_we    (fmin_we),
        .i_waddr (fmin_waddr),
        .i_wdata (fmin_wdata),
        .i_re    (fmin_re),
        .i_raddr (fmin_raddr),
        .o_rdata (fmin_rdata)
    );

    lpso_scan #(
        .SW (SW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_s_ctl),
        .i_clear_best (clear_best),
        .i_col_rd     (col_rdata),
        .i_fmin_rd    (fmin_rdata),
        .o_col_run    (col_run),
        .o_fmin       (fmin_wdata),
        .o_best       (best)
    );

    // Present the saturated order for one cycle.
    assign o_order_valid = r_emit;
    assign o_order = (int'(best) > lpso_pkg::ORDER_MAX) ?
                     lpso_pkg::ORDER_W'(lpso_pkg::ORDER_MAX) : lpso_pkg::ORDER_W'(best);

    // A column run is never read in the cycle its entry is being written.
    a_col_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(col_re && col_we && (r_j == r_s_j)))
        else $error("column run read collides with its write");

    // Forward minimum reads and writes belong to different passes.
    a_fmin_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fmin_re && fmin_we))
        else $error("forward minimum read overlaps a write");

    // A result follows only the end of a scan or an empty-grid compute.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_order_valid |-> ($past(r_state) == ST_FIN) || ($past(r_state) == ST_IDLE))
        else $error("result strobe without a finished compute");

    // A blocked-cell write-back always follows its row read.
    a_blk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLK_WR) |-> ($past(r_state) == ST_BLK_RD))
        else $error("block write-back without row read");

endmodule

`default_nettype wire

// ===== design/lpso_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lpso_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a same-address collision.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/lpso_scan.sv =====
// Per-cell run update, minimum and running maximum of the plus sign scan.
`default_nettype none

module lpso_scan #(
    parameter int SW = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpso_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_clear_best,
    input  wire logic [SW-1:0]      i_col_rd,
    input  wire logic [SW-1:0]      i_fmin_rd,
    output logic      [SW-1:0]      o_col_run,
    output logic      [SW-1:0]      o_fmin,
    output logic      [SW-1:0]      o_best
);

    logic [SW-1:0] r_run;
    logic [SW-1:0] n_run;
    logic [SW-1:0] r_best;
    logic [SW-1:0] n_best;
    logic [SW-1:0] run_prev;
    logic [SW-1:0] col_prev;
    logic [SW-1:0] col_new;
    logic [SW-1:0] leg;
    logic [SW-1:0] cand;

    // Extend the row run and the column run through this cell.
    always_comb begin
        run_prev = i_ctl.row_start ? '0 : r_run;
        col_prev = i_ctl.first_row ? '0 : i_col_rd;
        n_run    = i_ctl.blocked ? '0 : run_prev + SW'(1);
        col_new  = i_ctl.blocked ? '0 : col_prev + SW'(1);
        leg      = (n_run < col_new) ? n_run : col_new;
        cand     = (leg < i_fmin_rd) ? leg : i_fmin_rd;
    end

    // Track the best arm length over open cells of the backward pass.
    always_comb begin
        n_best = r_best;
        if (i_clear_best) begin
            n_best = '0;
        end else if (i_ctl.valid && i_ctl.bwd && !i_ctl.blocked && (cand > r_best)) begin
            n_best = cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_best <= '0;
        end else begin
            if (i_ctl.valid) begin
                r_run <= n_run;
            end
            r_best <= n_best;
        end
    end

    assign o_col_run = col_new;
    assign o_fmin    = leg;
    assign o_best    = r_best;

endmodule

`default_nettype wire

// ===== tb/sv/largest_plus_sign_order_tb.sv =====
// Self-checking testbench for the largest plus sign order block.
module largest_plus_sign_order_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_CAP    = 64;
    localparam int ITEM_TARGET = 1200;
    localparam int TIMEOUT_NS  = 400_000_000;

    // Track the grid and predict the order for every compute transaction.
    class order_board;
        bit [GRID_CAP-1:0] blocked [GRID_CAP];
        logic [6:0]        size_reg;
        logic [lpso_pkg::ORDER_W-1:0] pending_orders[$];
        int n_items, n_ignored, n_blocks, n_computes, n_checked, n_errors;
        int n_resizes, peak_order;

        function new();
            size_reg = 7'd64;
            foreach (blocked[i]) blocked[i] = '0;
        endfunction

        function int size_in_use();
            return (size_reg > GRID_CAP) ? GRID_CAP : int'(size_reg);
        endfunction

        task report(string msg);
            n_errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        function void set_size(logic [6:0] sz);
            size_reg = sz;
            n_resizes++;
        endfunction

        // Forward pass keeps min(left, up); backward pass folds in right and down.
        function logic [lpso_pkg::ORDER_W-1:0] plus_order();
            int n, best, left, right_run, v;
            int col_run [GRID_CAP];
            int fwd_min [GRID_CAP][GRID_CAP];
            n = size_in_use();
            best = 0;
            if (n == 0) return '0;
            for (int j = 0; j < n; j++) col_run[j] = 0;
            for (int i = 0; i < n; i++) begin
                left = 0;
                for (int j = 0; j < n; j++) begin
                    if (blocked[i][j]) begin
                        left = 0;
                        col_run[j] = 0;
                    end else begin
                        left++;
                        col_run[j]++;
                    end
                    fwd_min[i][j] = (left < col_run[j]) ? left : col_run[j];
                end
            end
            for (int j = 0; j < n; j++) col_run[j] = 0;
            for (int i = n - 1; i >= 0; i--) begin
                right_run = 0;
                for (int j = n - 1; j >= 0; j--) begin
                    if (blocked[i][j]) begin
                        right_run = 0;
                        col_run[j] = 0;
                    end else begin
                        right_run++;
                        col_run[j]++;
                        v = (right_run < col_run[j]) ? right_run : col_run[j];
                        if (fwd_min[i][j] < v) v = fwd_min[i][j];
                        if (v > best) best = v;
                    end
                end
            end
            if (best > lpso_pkg::ORDER_MAX) best = lpso_pkg::ORDER_MAX;
            return best[lpso_pkg::ORDER_W-1:0];
        endfunction

        // Apply one accepted transaction to the grid.
        function void note_input(lpso_pkg::t_op op, logic [5:0] r, logic [5:0] c);
            int n;
            n = size_in_use();
            case (op)
                lpso_pkg::OP_CLEAR: begin
                    foreach (blocked[i]) blocked[i] = '0;
                    n_items++;
                end
                lpso_pkg::OP_BLOCK: begin
                    if (r < n && c < n) begin
                        blocked[r][c] = 1'b1;
                        n_items++;
                        n_blocks++;
                    end else begin
                        n_ignored++;
                    end
                end
                lpso_pkg::OP_COMPUTE: begin
                    pending_orders.push_back(plus_order());
                    n_items++;
                    n_computes++;
                end
                default: n_ignored++;
            endcase
        endfunction

        task check_order(logic [lpso_pkg::ORDER_W-1:0] got);
            logic [lpso_pkg::ORDER_W-1:0] want;
            if (pending_orders.size() == 0) begin
                report($sformatf("order %0d with no compute outstanding", got));
            end else begin
                want = pending_orders.pop_front();
                n_checked++;
                if (got !== want)
                    report($sformatf("order got %0d, want %0d (size %0d)",
                                     got, want, size_reg));
                if (int'(want) > peak_order) peak_order = want;
            end
        endtask
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    lpso_pkg::t_op op_q = lpso_pkg::OP_NONE;
    logic [5:0]    row_q = '0;
    logic [5:0]    col_q = '0;
    logic          o_order_valid;
    logic [lpso_pkg::ORDER_W-1:0] o_order;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [6:0]    i_cfg_data = '0;

    order_board board = new();
    bit quiet_phase = 1'b0;

    largest_plus_sign_order #(.MAX_SIDE(GRID_CAP)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (op_q),
        .i_row        (row_q),
        .i_col        (col_q),
        .o_order_valid(o_order_valid),
        .o_order      (o_order),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Observe transactions, results and register writes at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_input(op_q, row_q, col_q);
            if (o_order_valid) board.check_order(o_order);
            if (i_cfg_valid && o_cfg_ready) board.set_size(i_cfg_data);
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold the transaction until the block takes it, then idle for a random gap, which may be zero.
    task automatic send(lpso_pkg::t_op op, logic [5:0] r, logic [5:0] c);
        int gap;
        gap = rand_gap();
        start <= 1'b1;
        op_q  <= op;
        row_q <= r;
        col_q <= c;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain results, let a trailing clear finish, then wait for busy to drop.
    task automatic wait_idle();
        start <= 1'b0;
        while (board.pending_orders.size() != 0) @(posedge i_clk);
        repeat (GRID_CAP + 8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_size(logic [6:0] sz);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [5:0] rand6();
        return 6'($urandom_range(0, 63));
    endfunction

    // Clear (most of the time), block a batch of cells with some noise mixed in, then compute, sometimes twice.
    task automatic run_sequence(int n_eff);
        int cap, blocks, pick;
        if ($urandom_range(0, 3) != 0) send(lpso_pkg::OP_CLEAR, rand6(), rand6());
        cap = (n_eff * n_eff) / 2;
        if (cap > 60) cap = 60;
        if (cap < 3) cap = 3;
        blocks = $urandom_range(0, cap);
        repeat (blocks) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send(lpso_pkg::OP_NONE, rand6(), rand6());
            else if (pick < 3 || n_eff == 0)
                send(lpso_pkg::OP_BLOCK, rand6(), rand6());
            else
                send(lpso_pkg::OP_BLOCK, 6'($urandom_range(0, n_eff - 1)),
                     6'($urandom_range(0, n_eff - 1)));
        end
        send(lpso_pkg::OP_COMPUTE, rand6(), rand6());
        if (n_eff <= 32 && $urandom_range(0, 5) == 0)
            send(lpso_pkg::OP_COMPUTE, rand6(), rand6());
    endtask

    initial begin
        int pick, n_eff, seqs, large_left;
        logic [6:0] sz;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full grid at reset size, corners, unused op code.
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        send(lpso_pkg::OP_NONE, 6'd63, 6'd63);
        send(lpso_pkg::OP_BLOCK, 6'd63, 6'd63);
        send(lpso_pkg::OP_BLOCK, 6'd0, 6'd0);
        send(lpso_pkg::OP_BLOCK, 6'd31, 6'd32);
        send(lpso_pkg::OP_COMPUTE, 6'd63, 6'd63);
        // Smallest grid: blocked cell survives the resize, then clear.
        write_size(7'd1);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        send(lpso_pkg::OP_CLEAR, 6'd0, 6'd0);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        send(lpso_pkg::OP_BLOCK, 6'd1, 6'd1);
        send(lpso_pkg::OP_BLOCK, 6'd0, 6'd0);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        // Empty grid: block ignored, answer zero.
        write_size(7'd0);
        send(lpso_pkg::OP_BLOCK, 6'd0, 6'd0);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        // Cells just outside the grid are dropped.
        write_size(7'd5);
        send(lpso_pkg::OP_CLEAR, 6'd63, 6'd63);
        send(lpso_pkg::OP_BLOCK, 6'd5, 6'd0);
        send(lpso_pkg::OP_BLOCK, 6'd0, 6'd5);
        send(lpso_pkg::OP_BLOCK, 6'd2, 6'd2);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        // Grow without clearing, then a size above the storage limit.
        write_size(7'd9);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);
        write_size(7'd127);
        send(lpso_pkg::OP_BLOCK, 6'd40, 6'd40);
        send(lpso_pkg::OP_COMPUTE, 6'd0, 6'd0);

        // Random phases, mostly small grids, a few full-size ones.
        large_left = 3;
        while (board.n_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                sz = 7'($urandom_range(1, 12));
            else if (pick < 92)
                sz = 7'($urandom_range(13, 32));
            else if (pick < 95)
                sz = 7'd0;
            else if (large_left > 0) begin
                sz = 7'($urandom_range(64, 127));
                large_left--;
            end else
                sz = 7'($urandom_range(1, 12));
            write_size(sz);
            n_eff = (sz > GRID_CAP) ? GRID_CAP : int'(sz);
            quiet_phase = ($urandom_range(0, 3) == 0);
            seqs = (n_eff > 32) ? 2 : $urandom_range(2, 6);
            repeat (seqs) run_sequence(n_eff);
        end

        wait_idle();
        $display("summary: %0d transactions (%0d cell blocks, %0d computes, %0d ignored)",
                 board.n_items + board.n_ignored, board.n_blocks, board.n_computes,
                 board.n_ignored);
        $display("summary: %0d orders checked, largest %0d, %0d grid size writes",
                 board.n_checked, board.peak_order, board.n_resizes);
        if (board.n_errors == 0)
            $display("largest_plus_sign_order_tb: done, clean");
        else
            $display("largest_plus_sign_order_tb: done, errors");
        $finish;
    end

    // Hard stop if results never arrive.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d orders outstanding", board.pending_orders.size());
        $display("largest_plus_sign_order_tb: done, errors");
        $finish;
    end

endmodule
